### rtl/rtp_hdr_pkg.sv
package rtp_hdr_pkg;

	localparam int unsigned FIXED_HDR_BYTES = 12;
	localparam logic [1:0]  RTP_VERSION     = 2'd2;
	// wide enough for 12 + 60 + 4 + 4 * 65535
	localparam int unsigned SUM_W           = 19;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_SHORT    = 3'd1,
		ERR_CSRC     = 3'd2,
		ERR_EXT_HDR  = 3'd3,
		ERR_EXT_DATA = 3'd4
	} err_t;

	typedef struct packed {
		logic [7:0]  first_byte;
		logic [7:0]  second_byte;
		logic [15:0] seq;
		logic [31:0] ts;
		logic [31:0] ssrc;
		logic [15:0] ext_words;
	} hdr_cap_t;

	typedef struct packed {
		logic        ok;
		err_t        error_code;
		logic        marker;
		logic [6:0]  payload_type;
		logic [15:0] seq;
		logic [31:0] ts;
		logic [31:0] ssrc;
		logic [15:0] header_length;
	} hdr_res_t;

endpackage

### rtl/rtp_hdr_check.sv
module rtp_hdr_check #(
	parameter int unsigned POS_W = 16
) (
	input  rtp_hdr_pkg::hdr_cap_t cap,
	input  logic [POS_W-1:0]      len,
	output rtp_hdr_pkg::hdr_res_t res
);

	logic [6:0]                     fix_len;
	logic [rtp_hdr_pkg::SUM_W-1:0]  fix_w;
	logic [rtp_hdr_pkg::SUM_W-1:0]  ext_hdr_end;
	logic [rtp_hdr_pkg::SUM_W-1:0]  ext_end;
	logic [rtp_hdr_pkg::SUM_W-1:0]  len_w;
	logic [rtp_hdr_pkg::SUM_W-1:0]  hdr_len;
	logic                           has_ext;
	rtp_hdr_pkg::err_t              err;

	// fixed part plus csrc list
	assign fix_len     = 7'(rtp_hdr_pkg::FIXED_HDR_BYTES) + {1'b0, cap.first_byte[3:0], 2'b00};
	assign fix_w       = rtp_hdr_pkg::SUM_W'(fix_len);
	assign ext_hdr_end = fix_w + rtp_hdr_pkg::SUM_W'(4);
	assign ext_end     = ext_hdr_end + rtp_hdr_pkg::SUM_W'({cap.ext_words, 2'b00});
	assign len_w       = rtp_hdr_pkg::SUM_W'(len);
	assign has_ext     = cap.first_byte[4];
	assign hdr_len     = has_ext ? ext_end : fix_w;

	always_comb begin
		if (len_w < rtp_hdr_pkg::SUM_W'(rtp_hdr_pkg::FIXED_HDR_BYTES)
				|| cap.first_byte[7:6] != rtp_hdr_pkg::RTP_VERSION) begin
			err = rtp_hdr_pkg::ERR_SHORT;
		end else if (fix_w > len_w) begin
			err = rtp_hdr_pkg::ERR_CSRC;
		end else if (has_ext && ext_hdr_end > len_w) begin
			err = rtp_hdr_pkg::ERR_EXT_HDR;
		end else if (has_ext && ext_end > len_w) begin
			err = rtp_hdr_pkg::ERR_EXT_DATA;
		end else begin
			err = rtp_hdr_pkg::ERR_NONE;
		end
	end

	always_comb begin
		res = '0;
		res.error_code = err;
		if (err == rtp_hdr_pkg::ERR_NONE) begin
			res.ok            = 1'b1;
			res.marker        = cap.second_byte[7];
			res.payload_type  = cap.second_byte[6:0];
			res.seq           = cap.seq;
			res.ts            = cap.ts;
			res.ssrc          = cap.ssrc;
			res.header_length = hdr_len[15:0];
		end
	end

endmodule

### rtl/rtp_header_parser.sv
// RTP fixed-header parser: takes one packet byte per beat, last_byte on the final one, and
// gives one result beat per packet with the header fields and total header length, or an
// error code with all other fields zero. A byte is taken every cycle while the result side
// keeps up; each byte passes an input register, then position compare and capture into the
// header registers, and on the last byte the length checks feed the result register. Only
// a last byte waiting on a held result stalls the input. The byte count saturates at
// MAX_PACKET_BYTES.
module rtp_header_parser #(
	parameter int unsigned MAX_PACKET_BYTES = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [2:0]  error_code,
	output logic        marker,
	output logic [6:0]  payload_type,
	output logic [15:0] sequence_number,
	output logic [31:0] rtp_timestamp,
	output logic [31:0] source_id,
	output logic [15:0] header_length
);

	localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);

	logic                   valid_s1;
	logic [7:0]             data_byte_s1;
	logic                   last_byte_s1;
	logic                   adv_s1;
	logic                   fire_s1;

	logic [POS_W-1:0]       pos_q;
	logic [POS_W-1:0]       pos_next;
	rtp_hdr_pkg::hdr_cap_t  cap_q;
	rtp_hdr_pkg::hdr_cap_t  cap_next;
	rtp_hdr_pkg::hdr_res_t  res_next;
	rtp_hdr_pkg::hdr_res_t  res_q;
	logic                   out_valid_q;

	logic [16:0]            idx_w;
	logic [6:0]             ext_at;
	logic [16:0]            ext_at_w;

	assign adv_s1   = !last_byte_s1 || !out_valid_q || out_ready;
	assign fire_s1  = valid_s1 && adv_s1;
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_byte_s1 <= data_byte;
			last_byte_s1 <= last_byte;
		end
	end

	assign idx_w    = 17'(pos_q);
	assign pos_next = (pos_q < POS_W'(MAX_PACKET_BYTES)) ? pos_q + POS_W'(1) : pos_q;

	always_comb begin
		cap_next = cap_q;
		case (idx_w) inside
			17'd0: begin
				cap_next.first_byte = data_byte_s1;
			end
			17'd1: begin
				cap_next.second_byte = data_byte_s1;
			end
			[17'd2:17'd3]: begin
				cap_next.seq = {cap_q.seq[7:0], data_byte_s1};
			end
			[17'd4:17'd7]: begin
				cap_next.ts = {cap_q.ts[23:0], data_byte_s1};
			end
			[17'd8:17'd11]: begin
				cap_next.ssrc = {cap_q.ssrc[23:0], data_byte_s1};
			end
			default: begin
			end
		endcase
		// extension length sits two bytes past the csrc list
		if (idx_w != 17'd0 && cap_next.first_byte[4]
				&& (idx_w == ext_at_w || idx_w == ext_at_w + 17'd1)) begin
			cap_next.ext_words = {cap_q.ext_words[7:0], data_byte_s1};
		end
	end

	assign ext_at   = 7'(rtp_hdr_pkg::FIXED_HDR_BYTES + 2)
		+ {1'b0, cap_next.first_byte[3:0], 2'b00};
	assign ext_at_w = 17'(ext_at);

	rtp_hdr_check #(
		.POS_W (POS_W)
	) u_check (
		.cap (cap_next),
		.len (pos_next),
		.res (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cap_q <= '0;
		end else if (fire_s1) begin
			if (last_byte_s1) begin
				pos_q <= '0;
				cap_q <= '0;
			end else begin
				pos_q <= pos_next;
				cap_q <= cap_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_byte_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_byte_s1) begin
			res_q <= res_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign ok              = res_q.ok;
	assign error_code      = res_q.error_code;
	assign marker          = res_q.marker;
	assign payload_type    = res_q.payload_type;
	assign sequence_number = res_q.seq;
	assign rtp_timestamp   = res_q.ts;
	assign source_id       = res_q.ssrc;
	assign header_length   = res_q.header_length;

endmodule

### rtl/rtp_hdr_checker.sv
module rtp_hdr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  data_byte,
	input logic        last_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic        ok,
	input logic [2:0]  error_code,
	input logic        marker,
	input logic [6:0]  payload_type,
	input logic [15:0] sequence_number,
	input logic [31:0] rtp_timestamp,
	input logic [31:0] source_id,
	input logic [15:0] header_length
);

	// waiting byte beat keeps its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(last_byte))
		else $error("byte beat changed while stalled");

	// held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(error_code)
			&& $stable(header_length) && $stable(source_id))
		else $error("result beat changed while stalled");

	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ok == (error_code == rtp_hdr_pkg::ERR_NONE)
			&& (error_code == rtp_hdr_pkg::ERR_NONE || error_code == rtp_hdr_pkg::ERR_SHORT
			|| error_code == rtp_hdr_pkg::ERR_CSRC || error_code == rtp_hdr_pkg::ERR_EXT_HDR
			|| error_code == rtp_hdr_pkg::ERR_EXT_DATA))
		else $error("ok and error code disagree");

	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ok |-> header_length >= 16'd12 && header_length[1:0] == 2'b00)
		else $error("bad header length on good packet");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> header_length == 16'd0 && source_id == 32'd0
			&& rtp_timestamp == 32'd0 && sequence_number == 16'd0 && !marker
			&& payload_type == 7'd0)
		else $error("error result carries header fields");

endmodule

bind rtp_header_parser rtp_hdr_checker u_rtp_hdr_checker (.*);

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int unsigned MAX_BYTES  = 65535;
	localparam int unsigned RAND_BYTES = 880;
	localparam int unsigned RAND_PKTS  = 24;
	// byte counts between which neither side idles
	localparam int unsigned CALM_FROM  = 500;
	localparam int unsigned CALM_TO    = 800;

	typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

	typedef struct {
		logic [7:0] data;
		logic       lst;
		bit         drain;
	} pkt_byte_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        ok;
	logic [2:0]  error_code;
	logic        marker;
	logic [6:0]  payload_type;
	logic [15:0] sequence_number;
	logic [31:0] rtp_timestamp;
	logic [31:0] source_id;
	logic [15:0] header_length;

	pkt_byte_t              byte_beats[$];
	rtp_hdr_pkg::hdr_res_t  hdr_expected[$];
	int unsigned            total_beats = 0;
	int unsigned            n_taken     = 0;
	int unsigned            mismatches  = 0;

	// parser state as the block should hold it
	int unsigned pos_cnt;
	logic [7:0]  vcx_byte;
	logic [7:0]  mpt_byte;
	logic [15:0] seq_acc;
	logic [31:0] ts_acc;
	logic [31:0] ssrc_acc;
	logic [15:0] xlen_acc;

	pkt_byte_t              nxt_beat;
	rtp_hdr_pkg::hdr_res_t  new_res;
	rtp_hdr_pkg::hdr_res_t  want;

	rtp_header_parser #(
		.MAX_PACKET_BYTES(MAX_BYTES)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.ok             (ok),
		.error_code     (error_code),
		.marker         (marker),
		.payload_type   (payload_type),
		.sequence_number(sequence_number),
		.rtp_timestamp  (rtp_timestamp),
		.source_id      (source_id),
		.header_length  (header_length)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void clear_parse();
		pos_cnt  = 0;
		vcx_byte = '0;
		mpt_byte = '0;
		seq_acc  = '0;
		ts_acc   = '0;
		ssrc_acc = '0;
		xlen_acc = '0;
	endfunction

	// returns 1 when the byte closes a packet, with the header verdict in res
	function automatic bit parse_byte(input logic [7:0] b, input logic lst,
			output rtp_hdr_pkg::hdr_res_t res);
		int unsigned        idx;
		int unsigned        xat;
		int unsigned        len;
		int unsigned        hdr;
		rtp_hdr_pkg::err_t  err;
		idx = pos_cnt;
		res = '0;
		if (idx == 0)
			vcx_byte = b;
		else if (idx == 1)
			mpt_byte = b;
		else if (idx < 4)
			seq_acc = {seq_acc[7:0], b};
		else if (idx < 8)
			ts_acc = {ts_acc[23:0], b};
		else if (idx < rtp_hdr_pkg::FIXED_HDR_BYTES)
			ssrc_acc = {ssrc_acc[23:0], b};
		xat = rtp_hdr_pkg::FIXED_HDR_BYTES + 4 * vcx_byte[3:0] + 2;
		if (idx >= 1 && vcx_byte[4] && (idx == xat || idx == xat + 1))
			xlen_acc = {xlen_acc[7:0], b};
		if (pos_cnt < MAX_BYTES)
			pos_cnt++;
		if (!lst)
			return 1'b0;

		len = pos_cnt;
		err = rtp_hdr_pkg::ERR_NONE;
		hdr = 0;
		if (len < rtp_hdr_pkg::FIXED_HDR_BYTES
				|| vcx_byte[7:6] != rtp_hdr_pkg::RTP_VERSION) begin
			err = rtp_hdr_pkg::ERR_SHORT;
		end else begin
			hdr = rtp_hdr_pkg::FIXED_HDR_BYTES + 4 * vcx_byte[3:0];
			if (hdr > len) begin
				err = rtp_hdr_pkg::ERR_CSRC;
			end else if (vcx_byte[4]) begin
				if (hdr + 4 > len) begin
					err = rtp_hdr_pkg::ERR_EXT_HDR;
				end else begin
					hdr = hdr + 4 + 4 * xlen_acc;
					if (hdr > len)
						err = rtp_hdr_pkg::ERR_EXT_DATA;
				end
			end
		end
		if (err != rtp_hdr_pkg::ERR_NONE) begin
			res.error_code = err;
		end else begin
			res.ok            = 1'b1;
			res.error_code    = rtp_hdr_pkg::ERR_NONE;
			res.marker        = mpt_byte[7];
			res.payload_type  = mpt_byte[6:0];
			res.seq           = seq_acc;
			res.ts            = ts_acc;
			res.ssrc          = ssrc_acc;
			res.header_length = hdr[15:0];
		end
		clear_parse();
		return 1'b1;
	endfunction

	function automatic bit idle_now();
		if (n_taken >= CALM_FROM && n_taken < CALM_TO)
			return 1'b0;
		return $urandom_range(99) < 33;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	// queue one packet of n bytes; the extension length lands where the block looks for it
	task automatic make_packet(input logic [7:0] b0, input logic [7:0] b1,
			input int unsigned n, input logic [15:0] xw, input fill_t fill, input bit drain);
		int unsigned xat;
		pkt_byte_t   pb;
		xat = rtp_hdr_pkg::FIXED_HDR_BYTES + 4 * b0[3:0] + 2;
		for (int unsigned i = 0; i < n; i++) begin
			pb.drain = drain && (i == 0);
			pb.lst   = (i == n - 1);
			if (i == 0)
				pb.data = b0;
			else if (i == 1)
				pb.data = b1;
			else if (b0[4] && i == xat)
				pb.data = xw[15:8];
			else if (b0[4] && i == xat + 1)
				pb.data = xw[7:0];
			else begin
				case (fill)
					FILL_ZERO: pb.data = 8'h00;
					FILL_ONES: pb.data = 8'hff;
					default:   pb.data = 8'($urandom);
				endcase
			end
			byte_beats.push_back(pb);
		end
		total_beats += n;
	endtask

	task automatic random_packet(output int unsigned n);
		logic [7:0]  b0;
		int unsigned kind;
		int unsigned cc;
		int unsigned xw;
		int unsigned need;
		int unsigned bnd;
		bit          ext;
		kind = $urandom_range(99);
		cc   = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(2);
		ext  = 1'($urandom_range(1));
		xw   = $urandom_range(3);
		b0   = {rtp_hdr_pkg::RTP_VERSION, 1'($urandom_range(1)), ext, 4'(cc)};
		need = rtp_hdr_pkg::FIXED_HDR_BYTES + 4 * cc + (ext ? 4 + 4 * xw : 0);
		if (kind < 65) begin
			n = need + $urandom_range(8);
		end else if (kind < 85) begin
			// cut the packet around one of the length checks
			case ($urandom_range(3))
				0:       bnd = rtp_hdr_pkg::FIXED_HDR_BYTES;
				1:       bnd = rtp_hdr_pkg::FIXED_HDR_BYTES + 4 * cc;
				2:       bnd = rtp_hdr_pkg::FIXED_HDR_BYTES + 4 * cc + 4;
				default: bnd = need;
			endcase
			n = bnd - 1 + $urandom_range(2);
			if (ext && $urandom_range(1))
				xw = $urandom_range(16'hffff);
		end else begin
			b0 = 8'($urandom);
			n  = $urandom_range(24, 1);
			xw = $urandom_range(16'hffff);
		end
		make_packet(b0, 8'($urandom), n, 16'(xw), FILL_RAND, $urandom_range(19) == 0);
	endtask

	// driver: predicts on every accepted beat, then loads the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			data_byte <= '0;
			last_byte <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				if (parse_byte(data_byte, last_byte, new_res))
					hdr_expected.push_back(new_res);
				n_taken++;
			end
			if (!in_valid || in_ready) begin
				if (byte_beats.size() != 0 &&
						!(byte_beats[0].drain && hdr_expected.size() != 0) && !idle_now()) begin
					nxt_beat = byte_beats.pop_front();
					in_valid  <= 1'b1;
					data_byte <= nxt_beat.data;
					last_byte <= nxt_beat.lst;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (hdr_expected.size() == 0) begin
					$error("result beat with no packet pending");
					mismatches++;
				end else begin
					want = hdr_expected.pop_front();
					check_field("ok", 32'(want.ok), 32'(ok));
					check_field("error_code", 32'(want.error_code), 32'(error_code));
					check_field("marker", 32'(want.marker), 32'(marker));
					check_field("payload_type", 32'(want.payload_type), 32'(payload_type));
					check_field("sequence_number", 32'(want.seq), 32'(sequence_number));
					check_field("rtp_timestamp", want.ts, rtp_timestamp);
					check_field("source_id", want.ssrc, source_id);
					check_field("header_length", 32'(want.header_length), 32'(header_length));
				end
			end
			out_ready <= !idle_now();
		end
	end

	initial begin
		int unsigned rnd_bytes;
		int unsigned rnd_pkts;
		int unsigned n;
		clear_parse();
		rnd_bytes = 0;
		rnd_pkts  = 0;

		// single byte packet, then extreme field values
		make_packet(8'h80, 8'h00, 1, 16'h0000, FILL_ZERO, 1'b1);
		make_packet(8'ha0, 8'hff, 12, 16'h0000, FILL_ONES, 1'b0);
		make_packet(8'h80, 8'h00, 12, 16'h0000, FILL_ZERO, 1'b0);
		// wrong version, then one byte short
		make_packet(8'hc0, 8'h80, 12, 16'h0000, FILL_RAND, 1'b0);
		make_packet(8'h80, 8'h7f, 11, 16'h0000, FILL_RAND, 1'b0);
		// csrc list, extension header and extension data each past the end
		make_packet(8'h8f, 8'h11, 12, 16'h0000, FILL_RAND, 1'b0);
		make_packet(8'h90, 8'h22, 14, 16'h0000, FILL_RAND, 1'b1);
		make_packet(8'h90, 8'h33, 16, 16'hffff, FILL_RAND, 1'b0);
		// full csrc list plus one extension word, exact fit
		make_packet(8'h9f, 8'he0, 80, 16'h0001, FILL_RAND, 1'b0);

		while (rnd_bytes < RAND_BYTES || rnd_pkts < RAND_PKTS) begin
			random_packet(n);
			rnd_bytes += n;
			rnd_pkts++;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (n_taken != total_beats || hdr_expected.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
